>>> hdl/mrrp_pkg.sv
// Shared types, constants and character helpers for the receive record parser.
package mrrp_pkg;

  localparam int unsigned MAX_PAYLOAD = 255;

  localparam logic [7:0] SEP_FIELD = ",";
  localparam logic [7:0] SEP_LEN   = ":";
  localparam logic [7:0] CH_MINUS  = "-";
  localparam logic [7:0] CH_PLUS   = "+";
  localparam logic [7:0] CH_LO_A   = "a";
  localparam logic [7:0] CH_UP_A   = "A";

  // value of hex_of() for a character that is not a hex digit
  localparam logic [4:0] HEX_NONE = 5'd16;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_RSSI,
    PH_SNR,
    PH_LEN,
    PH_HEX,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    NS_START,
    NS_WS,
    NS_SIGN,
    NS_DIGITS
  } num_stage_t;

  typedef enum logic [2:0] {
    CL_HEX,
    CL_SPACE,
    CL_MINUS,
    CL_PLUS,
    CL_OTHER
  } char_class_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_BYTE   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SEP   = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_EARLY_END = 2'd3
  } status_t;

  typedef struct packed {
    logic               valid;
    kind_t              kind;
    status_t            status;
    logic signed [15:0] rssi;
    logic signed [15:0] snr;
    logic [7:0]         payload_len;
    logic [7:0]         data_byte;
    logic               last;
  } result_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == " ") || (c inside {[8'd9:8'd13]});
  endfunction

  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] h;
    h = HEX_NONE;
    if (c inside {["0":"9"]}) h = 5'(c - 8'h30);
    else if (c inside {["a":"f"]}) h = 5'(c - 8'h57);
    else if (c inside {["A":"F"]}) h = 5'(c - 8'h37);
    return h;
  endfunction

  // character of the receive prefix at a given position
  function automatic logic [7:0] pfx_char(input logic upper, input logic [2:0] idx);
    logic [7:0] p;
    case (idx)
      3'd0:    p = upper ? "A" : "a";
      3'd1:    p = upper ? "T" : "t";
      3'd2:    p = "+";
      3'd3:    p = upper ? "R" : "r";
      3'd4:    p = upper ? "E" : "e";
      3'd5:    p = upper ? "C" : "c";
      3'd6:    p = upper ? "V" : "v";
      3'd7:    p = "=";
      default: p = "=";
    endcase
    return p;
  endfunction

endpackage

>>> hdl/mrrp_core.sv
// Parse state and character step of the receive record parser.
module mrrp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        ch,
  input  logic              chunk_end,
  input  logic              enabled,
  output mrrp_pkg::result_t res
);

  typedef enum logic [1:0] {
    NR_CONT,
    NR_FIELD,
    NR_BAD
  } num_res_t;

  typedef struct packed {
    num_res_t               res;
    mrrp_pkg::num_stage_t   stage;
    logic [15:0]            acc;
    logic                   neg;
  } num_step_t;

  mrrp_pkg::phase_t       phase_r, phase_nxt;
  logic [2:0]             pidx_r, pidx_nxt;
  logic                   pupper_r, pupper_nxt;
  logic                   neg_r, neg_nxt;
  mrrp_pkg::num_stage_t   nstage_r, nstage_nxt;
  logic [15:0]            acc_r, acc_nxt;
  logic [15:0]            rssi_r, rssi_nxt;
  logic [15:0]            snr_r, snr_nxt;
  logic [7:0]             left_r, left_nxt;
  logic [3:0]             hnib_r, hnib_nxt;
  logic                   half_r, half_nxt;
  mrrp_pkg::char_class_t  fcls_r, fcls_nxt;

  logic                   err_c;
  mrrp_pkg::status_t      status_c;
  logic                   hdr_c;
  logic                   byte_c;
  logic [7:0]             byte_val_c;
  logic                   byte_last_c;

  function automatic num_step_t num_step(input logic [7:0] c, input logic [7:0] sep,
                                         input logic sat, input mrrp_pkg::num_stage_t stage,
                                         input logic [15:0] acc, input logic neg);
    num_step_t  r;
    logic [19:0] sum;
    r.res   = NR_CONT;
    r.stage = stage;
    r.acc   = acc;
    r.neg   = neg;
    sum = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + 20'(c - 8'h30);
    if (c inside {["0":"9"]}) begin
      r.stage = mrrp_pkg::NS_DIGITS;
      if (sat) begin
        // length saturates one above the limit so the check at ':' still fails
        if (sum > 20'(mrrp_pkg::MAX_PAYLOAD + 1)) r.acc = 16'(mrrp_pkg::MAX_PAYLOAD + 1);
        else r.acc = sum[15:0];
      end else begin
        r.acc = sum[15:0];
      end
    end else if (c == sep) begin
      if (stage == mrrp_pkg::NS_START || stage == mrrp_pkg::NS_DIGITS) r.res = NR_FIELD;
      else r.res = NR_BAD;
    end else if (mrrp_pkg::is_ws(c) &&
                 (stage == mrrp_pkg::NS_START || stage == mrrp_pkg::NS_WS)) begin
      r.stage = mrrp_pkg::NS_WS;
    end else if ((c == mrrp_pkg::CH_PLUS || c == mrrp_pkg::CH_MINUS) &&
                 (stage == mrrp_pkg::NS_START || stage == mrrp_pkg::NS_WS)) begin
      r.stage = mrrp_pkg::NS_SIGN;
      r.neg   = (c == mrrp_pkg::CH_MINUS);
    end else begin
      r.res = NR_BAD;
    end
    return r;
  endfunction

  num_step_t   num;
  logic [15:0] signed_val;
  logic [4:0]  dig;
  logic        dig_ok;
  logic [7:0]  left_dec;

  assign num = num_step(ch, (phase_r == mrrp_pkg::PH_LEN) ? mrrp_pkg::SEP_LEN
                                                          : mrrp_pkg::SEP_FIELD,
                        (phase_r == mrrp_pkg::PH_LEN), nstage_r, acc_r, neg_r);
  assign signed_val = neg_r ? (16'd0 - acc_r) : acc_r;
  assign dig        = mrrp_pkg::hex_of(ch);
  assign dig_ok     = (dig != mrrp_pkg::HEX_NONE);
  assign left_dec   = (left_r != 8'd0) ? (left_r - 8'd1) : 8'd0;

  // next state and result events
  always_comb begin
    phase_nxt   = phase_r;
    pidx_nxt    = pidx_r;
    pupper_nxt  = pupper_r;
    neg_nxt     = neg_r;
    nstage_nxt  = nstage_r;
    acc_nxt     = acc_r;
    rssi_nxt    = rssi_r;
    snr_nxt     = snr_r;
    left_nxt    = left_r;
    hnib_nxt    = hnib_r;
    half_nxt    = half_r;
    fcls_nxt    = fcls_r;
    err_c       = 1'b0;
    status_c    = mrrp_pkg::ST_OK;
    hdr_c       = 1'b0;
    byte_c      = 1'b0;
    byte_val_c  = 8'd0;
    byte_last_c = 1'b0;

    if (!enabled) begin
      phase_nxt = chunk_end ? mrrp_pkg::PH_SEARCH : mrrp_pkg::PH_DONE;
      pidx_nxt  = 3'd0;
      half_nxt  = 1'b0;
    end else begin
      case (phase_r)
        mrrp_pkg::PH_SEARCH: begin
          if (pidx_r != 3'd0 && ch == mrrp_pkg::pfx_char(pupper_r, pidx_r)) begin
            if (pidx_r == 3'd7) begin
              pidx_nxt   = 3'd0;
              phase_nxt  = mrrp_pkg::PH_RSSI;
              neg_nxt    = 1'b0;
              nstage_nxt = mrrp_pkg::NS_START;
              acc_nxt    = 16'd0;
            end else begin
              pidx_nxt = pidx_r + 3'd1;
            end
          end else begin
            pidx_nxt = 3'd0;
            if (ch == mrrp_pkg::CH_LO_A) begin
              pupper_nxt = 1'b0;
              pidx_nxt   = 3'd1;
            end else if (ch == mrrp_pkg::CH_UP_A) begin
              pupper_nxt = 1'b1;
              pidx_nxt   = 3'd1;
            end
          end
        end
        mrrp_pkg::PH_RSSI, mrrp_pkg::PH_SNR: begin
          nstage_nxt = num.stage;
          acc_nxt    = num.acc;
          neg_nxt    = num.neg;
          if (num.res == NR_FIELD) begin
            if (phase_r == mrrp_pkg::PH_RSSI) begin
              rssi_nxt  = signed_val;
              phase_nxt = mrrp_pkg::PH_SNR;
            end else begin
              snr_nxt   = signed_val;
              phase_nxt = mrrp_pkg::PH_LEN;
            end
            neg_nxt    = 1'b0;
            nstage_nxt = mrrp_pkg::NS_START;
            acc_nxt    = 16'd0;
          end else if (num.res == NR_BAD) begin
            err_c    = 1'b1;
            status_c = mrrp_pkg::ST_BAD_SEP;
          end
        end
        mrrp_pkg::PH_LEN: begin
          nstage_nxt = num.stage;
          acc_nxt    = num.acc;
          neg_nxt    = num.neg;
          if (num.res == NR_BAD) begin
            err_c    = 1'b1;
            status_c = mrrp_pkg::ST_BAD_SEP;
          end else if (num.res == NR_FIELD) begin
            if (acc_r > 16'(mrrp_pkg::MAX_PAYLOAD) || (neg_r && acc_r != 16'd0)) begin
              err_c    = 1'b1;
              status_c = mrrp_pkg::ST_TOO_LONG;
            end else begin
              left_nxt  = acc_r[7:0];
              half_nxt  = 1'b0;
              hdr_c     = 1'b1;
              phase_nxt = (acc_r != 16'd0) ? mrrp_pkg::PH_HEX : mrrp_pkg::PH_DONE;
            end
          end
        end
        mrrp_pkg::PH_HEX: begin
          if (!half_r) begin
            hnib_nxt = dig[3:0];
            if (dig_ok) fcls_nxt = mrrp_pkg::CL_HEX;
            else if (mrrp_pkg::is_ws(ch)) fcls_nxt = mrrp_pkg::CL_SPACE;
            else if (ch == mrrp_pkg::CH_MINUS) fcls_nxt = mrrp_pkg::CL_MINUS;
            else if (ch == mrrp_pkg::CH_PLUS) fcls_nxt = mrrp_pkg::CL_PLUS;
            else fcls_nxt = mrrp_pkg::CL_OTHER;
            half_nxt = 1'b1;
          end else begin
            case (fcls_r)
              mrrp_pkg::CL_HEX:
                byte_val_c = dig_ok ? {hnib_r, dig[3:0]} : {4'd0, hnib_r};
              mrrp_pkg::CL_SPACE, mrrp_pkg::CL_PLUS:
                byte_val_c = dig_ok ? {4'd0, dig[3:0]} : 8'd0;
              mrrp_pkg::CL_MINUS:
                byte_val_c = dig_ok ? (8'd0 - {4'd0, dig[3:0]}) : 8'd0;
              default:
                byte_val_c = 8'd0;
            endcase
            half_nxt    = 1'b0;
            left_nxt    = left_dec;
            byte_c      = 1'b1;
            byte_last_c = (left_dec == 8'd0);
            phase_nxt   = (left_dec != 8'd0) ? mrrp_pkg::PH_HEX : mrrp_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
    end

    // chunk closing on an open record makes this character's result an early-end error, unless it already made an error
    if (!err_c && chunk_end && (phase_nxt inside {[mrrp_pkg::PH_RSSI:mrrp_pkg::PH_HEX]}))
    begin
      err_c    = 1'b1;
      status_c = mrrp_pkg::ST_EARLY_END;
    end
    if (err_c) phase_nxt = mrrp_pkg::PH_DONE;
    if (chunk_end) begin
      phase_nxt = mrrp_pkg::PH_SEARCH;
      pidx_nxt  = 3'd0;
      half_nxt  = 1'b0;
    end
  end

  // result assembly
  always_comb begin
    res             = '0;
    res.valid       = step && (err_c || hdr_c || byte_c);
    res.kind        = mrrp_pkg::KIND_HEADER;
    res.status      = mrrp_pkg::ST_OK;
    if (err_c) begin
      res.kind   = mrrp_pkg::KIND_ERROR;
      res.status = status_c;
      res.last   = 1'b1;
    end else if (hdr_c) begin
      res.kind        = mrrp_pkg::KIND_HEADER;
      res.rssi        = rssi_r;
      res.snr         = snr_r;
      res.payload_len = acc_r[7:0];
      res.last        = (acc_r == 16'd0);
    end else if (byte_c) begin
      res.kind      = mrrp_pkg::KIND_BYTE;
      res.data_byte = byte_val_c;
      res.last      = byte_last_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= mrrp_pkg::PH_SEARCH;
      pidx_r   <= 3'd0;
      pupper_r <= 1'b0;
      neg_r    <= 1'b0;
      nstage_r <= mrrp_pkg::NS_START;
      acc_r    <= 16'd0;
      rssi_r   <= 16'd0;
      snr_r    <= 16'd0;
      left_r   <= 8'd0;
      hnib_r   <= 4'd0;
      half_r   <= 1'b0;
      fcls_r   <= mrrp_pkg::CL_HEX;
    end else if (step) begin
      phase_r  <= phase_nxt;
      pidx_r   <= pidx_nxt;
      pupper_r <= pupper_nxt;
      neg_r    <= neg_nxt;
      nstage_r <= nstage_nxt;
      acc_r    <= acc_nxt;
      rssi_r   <= rssi_nxt;
      snr_r    <= snr_nxt;
      left_r   <= left_nxt;
      hnib_r   <= hnib_nxt;
      half_r   <= half_nxt;
      fcls_r   <= fcls_nxt;
    end
  end

endmodule

>>> hdl/modem_receive_record_parser_unit.sv
// Top level of the modem receive record parser: handshake, input and result registers.
// A character is held in the input register and parsed combinationally, and its result
// is written to the result register. Throughput: one character per cycle while results
// are taken; the parse step lies between the input register and the result register, and
// a waiting result stalls the input only when both registers are full.
// Reset: synchronous, active low; clears the valid flags of both registers, parse state and the enable.
module modem_receive_record_parser_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char,
  input  logic               in_chunk_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_result_kind,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_rssi,
  output logic signed [15:0] out_snr,
  output logic [7:0]         out_payload_len,
  output logic [7:0]         out_data_byte,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  logic              enabled_r;
  logic              in_vld_r, in_vld_nxt;
  logic [7:0]        in_char_r;
  logic              in_end_r;
  logic              out_vld_r, out_vld_nxt;
  mrrp_pkg::result_t res_r;
  mrrp_pkg::result_t core_res;
  logic              out_free;
  logic              step;
  logic              in_xfer;

  assign out_free = !out_vld_r || out_ready;
  assign step     = in_vld_r && out_free;
  assign in_ready = !in_vld_r || out_free;
  assign in_xfer  = in_valid && in_ready;

  mrrp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .ch        (in_char_r),
    .chunk_end (in_end_r),
    .enabled   (enabled_r),
    .res       (core_res)
  );

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_xfer) in_vld_nxt = 1'b1;
    else if (step) in_vld_nxt = 1'b0;
    out_vld_nxt = out_vld_r;
    if (out_free) out_vld_nxt = core_res.valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) enabled_r <= cfg_wdata;
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_char_r <= in_char;
      in_end_r  <= in_chunk_end;
    end
    if (core_res.valid) res_r <= core_res;
  end

  assign out_valid       = out_vld_r;
  assign out_result_kind = res_r.kind;
  assign out_status      = res_r.status;
  assign out_rssi        = res_r.rssi;
  assign out_snr         = res_r.snr;
  assign out_payload_len = res_r.payload_len;
  assign out_data_byte   = res_r.data_byte;
  assign out_last        = res_r.last;

endmodule
